/* src/gtj_pkg.sv */
// ----------------------------------------------------------------------------
// gtj_pkg
// Shared types and constants for the greedy text justifier.
// ----------------------------------------------------------------------------
package gtj_pkg;

  typedef enum logic [1:0] {
    OP_LETTER = 2'd0,
    OP_BREAK  = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [5:0] WIDTH_RESET  = 6'd40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIT,
    ST_LETTERS,
    ST_SPACES,
    ST_NEWLINE,
    ST_COPY
  } state_t;

endpackage

/* src/greedy_text_justifier.sv */
// ----------------------------------------------------------------------------
// greedy_text_justifier
// Greedy fully justified line filler for a byte stream of text.
// ----------------------------------------------------------------------------
// Input channel: push/full with operation and char_code. Letters collect a
// word, a word break commits it, end of text flushes the held line.
// Result channel: empty/pop with out_char and last; last marks the newline.
// A two-entry command queue parts the input side from the line builder.
// A word break checks whether the word fits and copies its letters into the
// line; when the line is full it first emits the line: a division by
// repeated subtraction of the gap count from the surplus, and then one output
// byte per cycle while pop does not hold the output register, with a step
// without output after each run of spaces.
// The output register is one beat deep; while pop stays low the builder holds
// in its output states and full rises once the queue fills. line_width is
// written with cfg_we/cfg_data; write it only while idle, the block does not
// enforce this. Reset empties the queue and the line and sets the width to 40.
// ----------------------------------------------------------------------------
module greedy_text_justifier #(
  parameter int LINE_BYTES = 64,
  parameter int MAX_WORDS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] char_code,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data
);

  logic [5:0] line_width;
  logic       cmd_valid;
  logic [1:0] cmd_op;
  logic [7:0] cmd_char;
  logic       cmd_take;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= gtj_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      line_width <= cfg_data;
    end
  end

  gtj_front u_front (
    .clk, .rst, .push, .full, .operation, .char_code,
    .cmd_valid, .cmd_op, .cmd_char, .cmd_take
  );

  gtj_back #(.LINE_BYTES(LINE_BYTES), .MAX_WORDS(MAX_WORDS)) u_back (
    .clk, .rst, .width(line_width),
    .cmd_valid, .cmd_op, .cmd_char, .cmd_take,
    .out_valid, .out_data(out_char), .out_last(last), .out_ready(pop)
  );

  assign empty = !out_valid;

endmodule

/* src/gtj_front.sv */
// ----------------------------------------------------------------------------
// gtj_front
// Input side: takes beats and places commands in a short queue.
// ----------------------------------------------------------------------------
module gtj_front (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] char_code,
  output logic       cmd_valid,
  output logic [1:0] cmd_op,
  output logic [7:0] cmd_char,
  input  logic       cmd_take
);

  logic [9:0] slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       do_push;
  logic       do_pop;

  assign full      = count == 2'd2;
  assign do_push   = push && !full && operation != gtj_pkg::OP_NONE;
  assign cmd_valid = count != 2'd0;
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd_op    = slot[rd_ptr][9:8];
  assign cmd_char  = slot[rd_ptr][7:0];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= {operation, char_code};
    end
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* src/gtj_back.sv */
// ----------------------------------------------------------------------------
// gtj_back
// Line builder: collects words, lays out justified lines byte by byte.
// ----------------------------------------------------------------------------
module gtj_back #(
  parameter int LINE_BYTES = 64,
  parameter int MAX_WORDS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [5:0] width,
  input  logic       cmd_valid,
  input  logic [1:0] cmd_op,
  input  logic [7:0] cmd_char,
  output logic       cmd_take,
  output logic       out_valid,
  output logic [7:0] out_data,
  output logic       out_last,
  input  logic       out_ready
);

  localparam int PW = $clog2(LINE_BYTES + 1);
  localparam int AW = $clog2(LINE_BYTES);
  localparam int NW = $clog2(MAX_WORDS + 1);
  localparam int WI = $clog2(MAX_WORDS);
  localparam int UW = PW + 1;

  logic [7:0]    line_mem [LINE_BYTES];
  logic [7:0]    word_mem [LINE_BYTES];
  logic [PW-1:0] len_mem  [MAX_WORDS];

  gtj_pkg::state_t state, state_next;
  logic [NW-1:0] word_count;
  logic [UW-1:0] used_width;
  logic [PW-1:0] pending_length;
  logic [PW-1:0] commit_len;
  logic          flush_pend;

  logic [UW-1:0] diff;
  logic [UW-1:0] base;
  logic [UW-1:0] extra;
  logic [UW-1:0] rem;
  logic [UW-1:0] div_cnt;
  logic [NW-1:0] emit_i;
  logic [PW-1:0] emit_j;
  logic [PW-1:0] cur_len;
  logic [UW-1:0] emit_pos;
  logic [UW-1:0] sp_cnt;
  logic [PW-1:0] copy_j;

  logic [5:0]    eff_w;
  logic [UW-1:0] effw_u;
  logic [NW-1:0] gaps;
  logic [PW-1:0] raw_len;
  logic          fits;
  logic          out_full;
  logic          emit_go;
  logic [7:0]    emit_data;
  logic          emit_last;
  logic [UW-1:0] gap_spaces;
  logic [UW-1:0] line_addr;
  logic [7:0]    line_rd;
  logic [PW-1:0] word_addr;
  logic [7:0]    word_rd;

  always_comb begin
    eff_w = (width == 6'd0) ? 6'd1 : width;
    if (UW'(eff_w) > UW'(LINE_BYTES - 1)) begin
      eff_w = 6'(LINE_BYTES - 1);
    end
  end
  assign effw_u  = UW'(eff_w);
  assign gaps    = word_count - NW'(1);
  assign raw_len = (UW'(pending_length) > effw_u) ? PW'(eff_w) : pending_length;
  assign fits    = (word_count < NW'(MAX_WORDS))
                   && (used_width + UW'(commit_len) + UW'(1) <= effw_u + UW'(1));
  assign cur_len = len_mem[emit_i[WI-1:0]];
  assign gap_spaces = (word_count == NW'(1)) ? diff
                      : base + UW'(1) + ((UW'(emit_i) < extra) ? UW'(1) : UW'(0));

  // read addresses run one entry ahead of the registered read data
  assign line_addr = (state == gtj_pkg::ST_LETTERS && emit_go) ? emit_pos + UW'(1) : emit_pos;
  assign word_addr = (state == gtj_pkg::ST_COPY) ? copy_j + PW'(1) : copy_j;

  // output register
  assign out_full = out_valid && !out_ready;
  assign emit_go  = !out_full;

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    unique case (state)
      gtj_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          priority if (cmd_op == gtj_pkg::OP_LETTER) begin
            state_next = gtj_pkg::ST_IDLE;
          end else if (cmd_op == gtj_pkg::OP_BREAK) begin
            state_next = (pending_length == PW'(0)) ? gtj_pkg::ST_IDLE : gtj_pkg::ST_FIT;
          end else begin
            state_next = gtj_pkg::ST_DIV;
          end
        end
      end
      gtj_pkg::ST_FIT: begin
        state_next = (!fits && word_count != NW'(0)) ? gtj_pkg::ST_DIV : gtj_pkg::ST_COPY;
      end
      gtj_pkg::ST_DIV: begin
        if (word_count <= NW'(1) || rem < UW'(gaps)) begin
          priority if (word_count == NW'(0)) begin
            state_next = gtj_pkg::ST_NEWLINE;
          end else if (cur_len == PW'(0)) begin
            state_next = gtj_pkg::ST_SPACES;
          end else begin
            state_next = gtj_pkg::ST_LETTERS;
          end
        end
      end
      gtj_pkg::ST_LETTERS: begin
        if (emit_go && emit_j + PW'(1) >= cur_len) begin
          state_next = (word_count == NW'(1) || emit_i + NW'(1) < word_count)
                       ? gtj_pkg::ST_SPACES : gtj_pkg::ST_NEWLINE;
        end
      end
      gtj_pkg::ST_SPACES: begin
        if (emit_go && sp_cnt >= gap_spaces) begin
          priority if (emit_i + NW'(1) >= word_count) begin
            state_next = gtj_pkg::ST_NEWLINE;
          end else if (len_mem[WI'(emit_i + NW'(1))] == PW'(0)) begin
            state_next = gtj_pkg::ST_SPACES;
          end else begin
            state_next = gtj_pkg::ST_LETTERS;
          end
        end else if (emit_go && gap_spaces == UW'(0)) begin
          state_next = gtj_pkg::ST_NEWLINE;
        end
      end
      gtj_pkg::ST_NEWLINE: begin
        if (emit_go) begin
          state_next = flush_pend ? gtj_pkg::ST_IDLE : gtj_pkg::ST_COPY;
        end
      end
      gtj_pkg::ST_COPY: begin
        if (copy_j + PW'(1) >= commit_len) begin
          state_next = gtj_pkg::ST_IDLE;
        end
      end
      default: state_next = gtj_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit_data = gtj_pkg::CHAR_SPACE;
    emit_last = 1'b0;
    unique case (state)
      gtj_pkg::ST_LETTERS: emit_data = line_rd;
      gtj_pkg::ST_NEWLINE: begin
        emit_data = gtj_pkg::CHAR_NEWLINE;
        emit_last = 1'b1;
      end
      default: emit_data = gtj_pkg::CHAR_SPACE;
    endcase
  end

  logic emit_strobe;
  always_comb begin
    emit_strobe = 1'b0;
    if (emit_go) begin
      unique case (state)
        gtj_pkg::ST_LETTERS: emit_strobe = 1'b1;
        gtj_pkg::ST_NEWLINE: emit_strobe = 1'b1;
        gtj_pkg::ST_SPACES:  emit_strobe = sp_cnt < gap_spaces;
        default:             emit_strobe = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    line_rd <= line_mem[line_addr[AW-1:0]];
    word_rd <= word_mem[word_addr[AW-1:0]];
    if (state == gtj_pkg::ST_IDLE && cmd_valid && cmd_op == gtj_pkg::OP_LETTER
        && pending_length < PW'(LINE_BYTES)) begin
      word_mem[pending_length[AW-1:0]] <= cmd_char;
    end
    if (state == gtj_pkg::ST_COPY && commit_len != PW'(0)) begin
      if (used_width - UW'(word_count) + UW'(copy_j) < UW'(LINE_BYTES)) begin
        line_mem[AW'(used_width - UW'(word_count) + UW'(copy_j))] <= word_rd;
      end
    end
    if (state == gtj_pkg::ST_COPY && state_next == gtj_pkg::ST_IDLE) begin
      len_mem[word_count[WI-1:0]] <= commit_len;
    end
    if (emit_strobe) begin
      out_data <= emit_data;
      out_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= gtj_pkg::ST_IDLE;
      word_count     <= '0;
      used_width     <= '0;
      pending_length <= '0;
      out_valid      <= 1'b0;
      flush_pend     <= 1'b0;
      commit_len     <= '0;
      diff <= '0; base <= '0; extra <= '0; rem <= '0; div_cnt <= '0;
      emit_i <= '0; emit_j <= '0; emit_pos <= '0; sp_cnt <= '0; copy_j <= '0;
    end else begin
      state <= state_next;
      if (emit_strobe) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        gtj_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd_op == gtj_pkg::OP_LETTER) begin
              if (pending_length < PW'(LINE_BYTES)) begin
                pending_length <= pending_length + PW'(1);
              end
            end else if (cmd_op == gtj_pkg::OP_BREAK) begin
              commit_len <= raw_len;
              flush_pend <= 1'b0;
            end else begin
              pending_length <= '0;
              flush_pend     <= 1'b1;
              diff    <= (effw_u + UW'(1) >= used_width) ? effw_u + UW'(1) - used_width : '0;
              rem     <= (effw_u + UW'(1) >= used_width) ? effw_u + UW'(1) - used_width : '0;
              div_cnt <= '0;
            end
            emit_i <= '0; emit_j <= '0; emit_pos <= '0; sp_cnt <= '0; copy_j <= '0;
          end
        end
        gtj_pkg::ST_FIT: begin
          diff    <= (effw_u + UW'(1) >= used_width) ? effw_u + UW'(1) - used_width : '0;
          rem     <= (effw_u + UW'(1) >= used_width) ? effw_u + UW'(1) - used_width : '0;
          div_cnt <= '0;
        end
        gtj_pkg::ST_DIV: begin
          // repeated subtraction of the gap count, one subtraction per cycle
          if (word_count > NW'(1) && rem >= UW'(gaps)) begin
            rem     <= rem - UW'(gaps);
            div_cnt <= div_cnt + UW'(1);
          end else begin
            base  <= div_cnt;
            extra <= rem;
          end
        end
        gtj_pkg::ST_LETTERS: begin
          if (emit_go) begin
            emit_pos <= emit_pos + UW'(1);
            if (emit_j + PW'(1) >= cur_len) begin
              emit_j <= '0;
              sp_cnt <= '0;
              if (!(word_count == NW'(1) || emit_i + NW'(1) < word_count)) begin
                emit_i <= emit_i + NW'(1);
              end
            end else begin
              emit_j <= emit_j + PW'(1);
            end
          end
        end
        gtj_pkg::ST_SPACES: begin
          if (emit_go) begin
            if (sp_cnt < gap_spaces) begin
              sp_cnt <= sp_cnt + UW'(1);
            end else begin
              sp_cnt <= '0;
              emit_i <= emit_i + NW'(1);
            end
          end
        end
        gtj_pkg::ST_NEWLINE: begin
          if (emit_go) begin
            word_count <= '0;
            used_width <= '0;
          end
        end
        gtj_pkg::ST_COPY: begin
          if (copy_j + PW'(1) >= commit_len) begin
            word_count     <= word_count + NW'(1);
            used_width     <= used_width + UW'(commit_len) + UW'(1);
            pending_length <= '0;
          end else begin
            copy_j <= copy_j + PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
